// ===== hdl/motor_command_framer_crc7_top_assert.svh =====
// assertion macros shared by the checker
`ifndef MOTOR_COMMAND_FRAMER_CRC7_TOP_ASSERT_SVH
`define MOTOR_COMMAND_FRAMER_CRC7_TOP_ASSERT_SVH

// same-cycle implication
`define MCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcf_pkg.sv =====
`default_nettype none

package mcf_pkg;

    typedef enum logic [1:0] {
        ACT_LINEAR  = 2'd0,
        ACT_CHAR    = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_REPLY   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_DEVICE = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_INVERT = 2'd2,
        CFG_POLY   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_REQ   = 2'd1,
        KIND_REPLY = 2'd2
    } t_kind;

    localparam int CFG_DATA_W = 15;

    typedef struct packed {
        logic [6:0]  device;
        logic [14:0] limit;
        logic        invert;
        logic [7:0]  poly;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{device: 7'd0, limit: 15'd32767, invert: 1'b0,
                                   poly: 8'd145};

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [15:0] pos;
        logic        pos_ok;
    } t_entry;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] SET_BASE  = 8'h40;
    localparam logic [7:0] REQ_CMD   = 8'h65;

    // motor characteristic in q16
    localparam logic [20:0] SLOPE_UNIT  = 21'd65536;
    localparam logic [20:0] SLOPE_OUTER = 21'd4552;
    localparam logic [20:0] SLOPE_MID   = 21'd120482;
    localparam logic [20:0] SLOPE_INNER = 21'd1024098;
    localparam logic [15:0] OFS_OUTER   = 16'd34734;
    localparam logic [15:0] OFS_MID     = 16'd16384;
    localparam logic signed [16:0] BRK_OUTER = 17'sd10369;
    localparam logic signed [16:0] BRK_INNER = 17'sd1172;

    localparam logic [9:0]  SCALE   = 10'd600;
    localparam logic [11:0] ENC_MID = 12'd2048;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam logic [Q_AW:0] Q_FULL = (Q_AW + 1)'(Q_DEPTH);

    // one byte through the reflected crc-7
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = c ^ poly;
            end
            c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mcf_ifs.sv =====
`default_nettype none

interface mcf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] power;
    logic [6:0]         var_offset;
    logic [6:0]         var_length;
    logic [7:0]         reply_low;
    logic [7:0]         reply_high;
    logic [7:0]         reply_crc;

    modport source (output valid, action, power, var_offset, var_length, reply_low,
                    reply_high, reply_crc, input ready);
    modport sink (input valid, action, power, var_offset, var_length, reply_low,
                  reply_high, reply_crc, output ready);
endinterface

interface mcf_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [15:0] position;
    logic               position_valid;

    modport source (output valid, tx_byte, last, position, position_valid, input ready);
    modport sink (input valid, tx_byte, last, position, position_valid, output ready);
endinterface

`default_nettype wire

// ===== hdl/motor_command_framer_crc7_top.sv =====
// path: a command passes registers s1 to s6 into the queue; its first byte is then registered
// throughput: one result per cycle while the receiver is ready; a set-power frame is 5 bytes,
//   a request frame 6 and a reply check 1 result; commands are taken every cycle until the
//   4-entry queue fills and the last pipeline stage is held
// reset: synchronous, active low; clears pipeline valids, queue pointers, byte counter and
//   output valid, and loads the registers with their defaults
`default_nettype none

module motor_command_framer_crc7_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mcf_cmd_if.sink                             i_cmd,
    mcf_rsp_if.source                           o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_idx,
    input  wire logic [mcf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mcf_pkg::t_cfg   r_cfg;
    mcf_pkg::t_entry push_entry;
    mcf_pkg::t_entry head_entry;
    logic            push;
    logic            push_ready;
    logic            head_valid;
    logic            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mcf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcf_pkg::CFG_DEVICE: r_cfg.device <= i_cfg_data[6:0];
                mcf_pkg::CFG_LIMIT:  r_cfg.limit  <= i_cfg_data[14:0];
                mcf_pkg::CFG_INVERT: r_cfg.invert <= i_cfg_data[0];
                mcf_pkg::CFG_POLY:   r_cfg.poly   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    mcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg        (r_cfg),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    mcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_ready (push_ready),
        .o_valid (head_valid),
        .o_data  (head_entry),
        .i_pop   (pop)
    );

    mcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_entry),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

// ===== hdl/mcf_front.sv =====
`default_nettype none

module mcf_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mcf_cmd_if.sink           i_cmd,
    input  var mcf_pkg::t_cfg i_cfg,
    input  wire logic         i_push_ready,
    output logic              o_push,
    output mcf_pkg::t_entry   o_entry
);

    typedef struct packed {
        mcf_pkg::t_kind kind;
        logic [15:0]    b34;
        logic [7:0]     rcrc;
        logic [7:0]     crc;
        logic           ok;
    } t_side;

    logic en;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    t_side r_s1_side, r_s2_side, r_s3_side, r_s4_side, r_s5_side, r_s6_side;
    t_side n_s1_side, n_s2_side, n_s3_side;

    logic signed [15:0] r_s1_p, n_s1_p;
    logic               r_s1_char;
    logic signed [15:0] r_s2_p, n_s2_p;
    logic [20:0]        r_s2_slope, n_s2_slope;
    logic [15:0]        r_s2_ofs, n_s2_ofs;
    logic               r_s2_oneg, n_s2_oneg;
    logic signed [37:0] r_s3_prod;
    logic [15:0]        r_s3_ofs;
    logic               r_s3_oneg;
    logic [33:0]        r_s4_num, n_s4_num;
    logic [31:0]        r_s5_mag, n_s5_mag;
    logic               r_s5_neg;
    logic [41:0]        s6_prod;
    logic [9:0]         r_s6_q;
    logic               r_s6_neg;
    logic [11:0]        v;

    assign en          = !r_s6_v || i_push_ready;
    assign i_cmd.ready = en;
    assign o_push      = r_s6_v && i_push_ready;

    // clamp and classify
    always_comb begin
        logic signed [16:0] p17;
        logic signed [16:0] lim17;
        logic signed [16:0] pc;
        p17   = {i_cmd.power[15], i_cmd.power};
        lim17 = {2'b00, i_cfg.limit};
        if (p17 > lim17) begin
            pc = lim17;
        end else if (p17 < -lim17) begin
            pc = -lim17;
        end else begin
            pc = p17;
        end
        n_s1_p = pc[15:0];
        case (i_cmd.action)
            mcf_pkg::ACT_REQUEST: n_s1_side.kind = mcf_pkg::KIND_REQ;
            mcf_pkg::ACT_REPLY:   n_s1_side.kind = mcf_pkg::KIND_REPLY;
            default:              n_s1_side.kind = mcf_pkg::KIND_SET;
        endcase
        if (i_cmd.action == mcf_pkg::ACT_REQUEST) begin
            n_s1_side.b34 = {1'b0, i_cmd.var_offset, 1'b0, i_cmd.var_length};
        end else begin
            n_s1_side.b34 = {i_cmd.reply_high, i_cmd.reply_low};
        end
        n_s1_side.rcrc = i_cmd.reply_crc;
        n_s1_side.crc  = mcf_pkg::crc_byte(8'h00, i_cmd.reply_low, i_cfg.poly);
        n_s1_side.ok   = 1'b0;
    end

    // segment select
    always_comb begin
        logic signed [16:0] x2;
        logic               oneg;
        x2 = {r_s1_p, 1'b0};
        if (!r_s1_char) begin
            n_s2_slope = mcf_pkg::SLOPE_UNIT;
            n_s2_ofs   = '0;
            oneg       = 1'b0;
        end else if (x2 < -mcf_pkg::BRK_OUTER) begin
            n_s2_slope = mcf_pkg::SLOPE_OUTER;
            n_s2_ofs   = mcf_pkg::OFS_OUTER;
            oneg       = 1'b1;
        end else if (x2 < -mcf_pkg::BRK_INNER) begin
            n_s2_slope = mcf_pkg::SLOPE_MID;
            n_s2_ofs   = mcf_pkg::OFS_MID;
            oneg       = 1'b1;
        end else if (x2 < mcf_pkg::BRK_INNER) begin
            n_s2_slope = mcf_pkg::SLOPE_INNER;
            n_s2_ofs   = '0;
            oneg       = 1'b0;
        end else if (x2 < mcf_pkg::BRK_OUTER) begin
            n_s2_slope = mcf_pkg::SLOPE_MID;
            n_s2_ofs   = mcf_pkg::OFS_MID;
            oneg       = 1'b0;
        end else begin
            n_s2_slope = mcf_pkg::SLOPE_OUTER;
            n_s2_ofs   = mcf_pkg::OFS_OUTER;
            oneg       = 1'b0;
        end
        // inversion folded into the operands
        n_s2_p    = i_cfg.invert ? -r_s1_p : r_s1_p;
        n_s2_oneg = oneg ^ i_cfg.invert;
        n_s2_side     = r_s1_side;
        n_s2_side.crc = mcf_pkg::crc_byte(r_s1_side.crc, r_s1_side.b34[15:8], i_cfg.poly);
    end

    always_comb begin
        n_s3_side    = r_s2_side;
        n_s3_side.ok = (r_s2_side.crc == r_s2_side.rcrc);
    end

    always_comb begin
        logic [33:0] ofs34;
        ofs34 = {3'b000, r_s3_ofs, 15'b0};
        if (r_s3_oneg) begin
            n_s4_num = r_s3_prod[33:0] - ofs34;
        end else begin
            n_s4_num = r_s3_prod[33:0] + ofs34;
        end
    end

    always_comb begin
        logic [33:0] neg_num;
        neg_num  = '0 - r_s4_num;
        n_s5_mag = r_s4_num[33] ? neg_num[31:0] : r_s4_num[31:0];
    end

    assign s6_prod = {10'b0, r_s5_mag} * {32'b0, mcf_pkg::SCALE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_cmd.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side  <= n_s1_side;
            r_s1_p     <= n_s1_p;
            r_s1_char  <= (i_cmd.action == mcf_pkg::ACT_CHAR);
            r_s2_side  <= n_s2_side;
            r_s2_p     <= n_s2_p;
            r_s2_slope <= n_s2_slope;
            r_s2_ofs   <= n_s2_ofs;
            r_s2_oneg  <= n_s2_oneg;
            r_s3_side  <= n_s3_side;
            r_s3_prod  <= $signed({1'b0, r_s2_slope}) * r_s2_p;
            r_s3_ofs   <= r_s2_ofs;
            r_s3_oneg  <= r_s2_oneg;
            r_s4_side  <= r_s3_side;
            r_s4_num   <= n_s4_num;
            r_s5_side  <= r_s4_side;
            r_s5_mag   <= n_s5_mag;
            r_s5_neg   <= r_s4_num[33];
            r_s6_side  <= r_s5_side;
            r_s6_q     <= s6_prod[40:31];
            r_s6_neg   <= r_s5_neg;
        end
    end

    // drive code around mid scale
    assign v = r_s6_neg ? mcf_pkg::ENC_MID - {2'b00, r_s6_q}
                        : mcf_pkg::ENC_MID + {2'b00, r_s6_q};

    always_comb begin
        o_entry.kind   = r_s6_side.kind;
        o_entry.b2     = mcf_pkg::SET_BASE + {3'b000, v[4:0]};
        o_entry.b3     = {1'b0, v[11:5]};
        o_entry.b4     = '0;
        o_entry.pos    = '0;
        o_entry.pos_ok = 1'b0;
        case (r_s6_side.kind)
            mcf_pkg::KIND_REQ: begin
                o_entry.b2 = mcf_pkg::REQ_CMD;
                o_entry.b3 = r_s6_side.b34[15:8];
                o_entry.b4 = r_s6_side.b34[7:0];
            end
            mcf_pkg::KIND_REPLY: begin
                o_entry.pos    = r_s6_side.ok ? r_s6_side.b34 : 16'd0;
                o_entry.pos_ok = r_s6_side.ok;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mcf_queue.sv =====
`default_nettype none

module mcf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  var mcf_pkg::t_entry  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output mcf_pkg::t_entry      o_data,
    input  wire logic            i_pop
);

    mcf_pkg::t_entry r_mem [mcf_pkg::Q_DEPTH];
    logic [mcf_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [mcf_pkg::Q_AW:0]   r_cnt;

    assign o_ready = (r_cnt != mcf_pkg::Q_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcf_back.sv =====
`default_nettype none

module mcf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  var mcf_pkg::t_cfg   i_cfg,
    input  wire logic           i_head_valid,
    input  var mcf_pkg::t_entry i_head,
    output logic                o_pop,
    mcf_rsp_if.source           o_rsp
);

    localparam logic [2:0] POS_SYNC = 3'd0;
    localparam logic [2:0] POS_ADDR = 3'd1;
    localparam logic [2:0] POS_CMD  = 3'd2;
    localparam logic [2:0] POS_DATA = 3'd3;
    localparam logic [2:0] LAST_SET = 3'd4;
    localparam logic [2:0] LAST_REQ = 3'd5;

    logic        load;
    logic        is_last;
    logic [7:0]  sel_byte;
    logic [7:0]  n_crc;
    logic [2:0]  r_idx;
    logic [7:0]  r_crc;
    logic        r_out_v;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [15:0] r_pos;
    logic        r_pos_ok;

    assign load  = !r_out_v || o_rsp.ready;
    assign o_pop = load && i_head_valid && is_last;

    always_comb begin
        case (i_head.kind)
            mcf_pkg::KIND_REPLY: is_last = 1'b1;
            mcf_pkg::KIND_REQ:   is_last = (r_idx == LAST_REQ);
            default:             is_last = (r_idx == LAST_SET);
        endcase
        case (r_idx)
            POS_SYNC: sel_byte = mcf_pkg::SYNC_BYTE;
            POS_ADDR: sel_byte = {1'b0, i_cfg.device};
            POS_CMD:  sel_byte = i_head.b2;
            POS_DATA: sel_byte = i_head.b3;
            default:  sel_byte = is_last ? r_crc : i_head.b4;
        endcase
        if (i_head.kind == mcf_pkg::KIND_REPLY) begin
            sel_byte = '0;
        end
        n_crc = is_last ? 8'h00 : mcf_pkg::crc_byte(r_crc, sel_byte, i_cfg.poly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_idx   <= '0;
            r_crc   <= '0;
        end else if (load) begin
            r_out_v <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_tx     <= sel_byte;
            r_last   <= is_last;
            r_pos    <= i_head.pos;
            r_pos_ok <= i_head.pos_ok;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.tx_byte        = r_tx;
    assign o_rsp.last           = r_last;
    assign o_rsp.position       = r_pos;
    assign o_rsp.position_valid = r_pos_ok;

endmodule

`default_nettype wire

// ===== hdl/mcf_sva.sv =====
`default_nettype none
`include "motor_command_framer_crc7_top_assert.svh"

module mcf_sva (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_ready,
    input wire logic [7:0]         i_tx_byte,
    input wire logic               i_last,
    input wire logic signed [15:0] i_position,
    input wire logic               i_position_valid
);

    `MCF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_tx_byte) && $stable(i_last), "result changed while stalled")
    `MCF_ASSERT_IMP(a_reply_last, i_clk, i_rst_n, i_valid && i_position_valid, i_last, "reply result not marked last")
    `MCF_ASSERT_IMP(a_reply_zero, i_clk, i_rst_n, i_valid && i_position_valid, i_tx_byte == 8'd0, "reply result carries a frame byte")
    `MCF_ASSERT_IMP(a_frame_nopos, i_clk, i_rst_n, i_valid && !i_last, i_position == 16'sd0 && !i_position_valid, "frame byte carries a position")
    `MCF_ASSERT_IMP(a_pos_checked, i_clk, i_rst_n, i_valid && i_position != 16'sd0, i_position_valid, "position shown without crc match")

endmodule

bind motor_command_framer_crc7_top mcf_sva u_sva (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_rsp.valid),
    .i_ready          (o_rsp.ready),
    .i_tx_byte        (o_rsp.tx_byte),
    .i_last           (o_rsp.last),
    .i_position       (o_rsp.position),
    .i_position_valid (o_rsp.position_valid)
);

`default_nettype wire

// ===== tb/tb_motor_command_framer_crc7_top.sv =====
module tb_motor_command_framer_crc7_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam mcf_pkg::t_action ACT_LINEAR  = mcf_pkg::ACT_LINEAR;
    localparam mcf_pkg::t_action ACT_CHAR    = mcf_pkg::ACT_CHAR;
    localparam mcf_pkg::t_action ACT_REQUEST = mcf_pkg::ACT_REQUEST;
    localparam mcf_pkg::t_action ACT_REPLY   = mcf_pkg::ACT_REPLY;

    localparam mcf_pkg::t_cfg_idx CFG_DEVICE = mcf_pkg::CFG_DEVICE;
    localparam mcf_pkg::t_cfg_idx CFG_LIMIT  = mcf_pkg::CFG_LIMIT;
    localparam mcf_pkg::t_cfg_idx CFG_INVERT = mcf_pkg::CFG_INVERT;
    localparam mcf_pkg::t_cfg_idx CFG_POLY   = mcf_pkg::CFG_POLY;

    localparam int         CFG_DATA_W = mcf_pkg::CFG_DATA_W;
    localparam logic [7:0] SYNC_BYTE  = mcf_pkg::SYNC_BYTE;
    localparam logic [7:0] SET_BASE   = mcf_pkg::SET_BASE;
    localparam logic [7:0] REQ_CMD    = mcf_pkg::REQ_CMD;

    localparam longint K_SLOPE_FAR  = 4552;
    localparam longint K_SLOPE_MID  = 120482;
    localparam longint K_SLOPE_NEAR = 1024098;
    localparam longint K_OFS_FAR    = 34734;
    localparam longint K_OFS_MID    = 16384;
    localparam longint K_KNEE_FAR   = 10369;
    localparam longint K_KNEE_NEAR  = 1172;
    localparam longint K_GAIN       = 600;
    localparam longint K_CENTRE     = 2048;
    localparam int     PCT_HEAVY    = 55;
    localparam int     PCT_LIGHT    = 17;
    localparam int     ITEMS_PER_PHASE = 21;

    typedef struct {
        mcf_pkg::t_action   action;
        logic signed [15:0] power;
        logic [6:0]         var_offset;
        logic [6:0]         var_length;
        logic [7:0]         reply_low;
        logic [7:0]         reply_high;
        logic [7:0]         reply_crc;
    } t_motor_cmd;

    typedef struct {
        logic [7:0]         tx_byte;
        logic               last;
        logic signed [15:0] position;
        logic               position_valid;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mcf_cmd_if cmd_bus ();
    mcf_rsp_if rsp_bus ();

    motor_command_framer_crc7_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // register copies as the block holds them
    logic [6:0]  reg_device = 7'd0;
    logic [14:0] reg_limit  = 15'd32767;
    logic        reg_invert = 1'b0;
    logic [7:0]  reg_poly   = 8'd145;

    t_motor_cmd  pending_cmds[$];
    t_frame_byte frames_due[$];
    int          n_loaded = 0;
    int          n_taken = 0;
    int          n_checked = 0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] crc7_over(input logic [7:0] b[6], input int n,
                                             input logic [7:0] poly);
        logic [7:0] c;
        int i, k;
        c = 8'd0;
        for (i = 0; i < n; i++) begin
            c = c ^ b[i];
            for (k = 0; k < 8; k++) begin
                if (c[0]) begin
                    c = c ^ poly;
                end
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] reply_check_byte(input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] b[6];
        b = '{default: 8'd0};
        b[0] = lo;
        b[1] = hi;
        return crc7_over(b, 2, reg_poly);
    endfunction

    // expected bytes of the frame (or reply check) caused by one request
    function automatic void predict_frame(input t_motor_cmd c);
        logic [7:0]  f[6];
        int          n, k;
        longint      p, lim, num, mag, q;
        logic [31:0] v;
        t_frame_byte r;
        f = '{default: 8'd0};
        if (c.action == ACT_REPLY) begin
            f[0] = c.reply_low;
            f[1] = c.reply_high;
            r.tx_byte = 8'd0;
            r.last = 1'b1;
            if (crc7_over(f, 2, reg_poly) == c.reply_crc) begin
                r.position = {c.reply_high, c.reply_low};
                r.position_valid = 1'b1;
            end else begin
                r.position = 16'sd0;
                r.position_valid = 1'b0;
            end
            frames_due.push_back(r);
            return;
        end
        f[0] = SYNC_BYTE;
        f[1] = {1'b0, reg_device};
        if (c.action == ACT_REQUEST) begin
            f[2] = REQ_CMD;
            f[3] = {1'b0, c.var_offset};
            f[4] = {1'b0, c.var_length};
            f[5] = crc7_over(f, 5, reg_poly);
            n = 6;
        end else begin
            p = longint'(c.power);
            lim = longint'(reg_limit);
            if (p > lim) begin
                p = lim;
            end
            if (p < -lim) begin
                p = -lim;
            end
            if (c.action == ACT_LINEAR) begin
                num = p * 65536;
            end else if (2 * p < -K_KNEE_FAR) begin
                num = K_SLOPE_FAR * p - K_OFS_FAR * 32768;
            end else if (2 * p < -K_KNEE_NEAR) begin
                num = K_SLOPE_MID * p - K_OFS_MID * 32768;
            end else if (2 * p < K_KNEE_NEAR) begin
                num = K_SLOPE_NEAR * p;
            end else if (2 * p < K_KNEE_FAR) begin
                num = K_SLOPE_MID * p + K_OFS_MID * 32768;
            end else begin
                num = K_SLOPE_FAR * p + K_OFS_FAR * 32768;
            end
            if (reg_invert) begin
                num = -num;
            end
            mag = (num < 0) ? -num : num;
            q = (mag * K_GAIN) >> 31;
            if (num < 0) begin
                q = -q;
            end
            v = 32'(q + K_CENTRE);
            f[2] = SET_BASE + {3'b000, v[4:0]};
            f[3] = {1'b0, v[11:5]};
            f[4] = crc7_over(f, 4, reg_poly);
            n = 5;
        end
        for (k = 0; k < n; k++) begin
            r.tx_byte = f[k];
            r.last = (k == n - 1);
            r.position = 16'sd0;
            r.position_valid = 1'b0;
            frames_due.push_back(r);
        end
    endfunction

    function automatic t_motor_cmd make_cmd(input mcf_pkg::t_action a, input logic [15:0] pw,
                                            input logic [6:0] off, input logic [6:0] len,
                                            input logic [7:0] lo, input logic [7:0] hi,
                                            input logic [7:0] crc);
        t_motor_cmd c;
        c.action = a;
        c.power = pw;
        c.var_offset = off;
        c.var_length = len;
        c.reply_low = lo;
        c.reply_high = hi;
        c.reply_crc = crc;
        return c;
    endfunction

    function automatic t_motor_cmd random_cmd();
        t_motor_cmd c;
        int knee;
        c.action = mcf_pkg::t_action'($urandom_range(3));
        c.var_offset = 7'($urandom);
        c.var_length = 7'($urandom);
        c.reply_low = 8'($urandom);
        c.reply_high = 8'($urandom);
        case ($urandom_range(5))
            0, 1: c.power = 16'($urandom);
            2: begin
                // around the breakpoints of the characteristic
                knee = ($urandom_range(1) ? 5184 : 585) + $urandom_range(2);
                c.power = 16'($urandom_range(1) ? knee : -knee);
            end
            3: begin
                knee = int'(reg_limit) + $urandom_range(4) - 2;
                c.power = 16'($urandom_range(1) ? knee : -knee);
            end
            4: begin
                case ($urandom_range(2))
                    0: c.power = 16'sh8000;
                    1: c.power = 16'sh7fff;
                    default: c.power = 16'sd0;
                endcase
            end
            default: c.power = 16'(int'($urandom_range(1200)) - 600);
        endcase
        if ($urandom_range(3) != 0) begin
            c.reply_crc = reply_check_byte(c.reply_low, c.reply_high);
        end else begin
            c.reply_crc = 8'($urandom);
        end
        return c;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || n_loaded != n_taken || frames_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [6:0] dev, input logic [14:0] lim,
                             input logic inv, input logic [7:0] poly);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DEVICE;
        i_cfg_data <= CFG_DATA_W'(dev);
        @(posedge i_clk);
        reg_device = dev;
        @(negedge i_clk);
        i_cfg_idx <= CFG_LIMIT;
        i_cfg_data <= CFG_DATA_W'(lim);
        @(posedge i_clk);
        reg_limit = lim;
        @(negedge i_clk);
        i_cfg_idx <= CFG_INVERT;
        i_cfg_data <= CFG_DATA_W'(inv);
        @(posedge i_clk);
        reg_invert = inv;
        @(negedge i_clk);
        i_cfg_idx <= CFG_POLY;
        i_cfg_data <= CFG_DATA_W'(poly);
        @(posedge i_clk);
        reg_poly = poly;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n, input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (n) pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_motor_cmd nxt;
        if (i_rst_n && n_loaded == n_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                cmd_bus.valid      <= 1'b1;
                cmd_bus.action     <= nxt.action;
                cmd_bus.power      <= nxt.power;
                cmd_bus.var_offset <= nxt.var_offset;
                cmd_bus.var_length <= nxt.var_length;
                cmd_bus.reply_low  <= nxt.reply_low;
                cmd_bus.reply_high <= nxt.reply_high;
                cmd_bus.reply_crc  <= nxt.reply_crc;
                n_loaded++;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted request -> expected frame
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            predict_frame(make_cmd(mcf_pkg::t_action'(cmd_bus.action), cmd_bus.power,
                                   cmd_bus.var_offset, cmd_bus.var_length,
                                   cmd_bus.reply_low, cmd_bus.reply_high, cmd_bus.reply_crc));
            n_taken++;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (frames_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result byte %02h last %0b pos %0d ok %0b",
                                        rsp_bus.tx_byte, rsp_bus.last, rsp_bus.position,
                                        rsp_bus.position_valid));
            end else begin
                want = frames_due.pop_front();
                if (rsp_bus.tx_byte !== want.tx_byte || rsp_bus.last !== want.last ||
                    rsp_bus.position !== want.position ||
                    rsp_bus.position_valid !== want.position_valid) begin
                    flag_mismatch($sformatf(
                        "result %0d expected byte %02h last %0b pos %0d ok %0b, got %02h %0b %0d %0b",
                        n_checked, want.tx_byte, want.last, want.position, want.position_valid,
                        rsp_bus.tx_byte, rsp_bus.last, rsp_bus.position, rsp_bus.position_valid));
                end
            end
            n_checked++;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEVICE;
        i_cfg_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.action = ACT_LINEAR;
        cmd_bus.power = 16'sd0;
        cmd_bus.var_offset = 7'd0;
        cmd_bus.var_length = 7'd0;
        cmd_bus.reply_low = 8'd0;
        cmd_bus.reply_high = 8'd0;
        cmd_bus.reply_crc = 8'd0;
        rsp_bus.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, breakpoints, every action, reply match and mismatch
        pending_cmds.push_back(make_cmd(ACT_LINEAR, 16'sh7fff, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_LINEAR, 16'sh8000, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_LINEAR, 16'sd0, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_LINEAR, -16'sd1, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sh7fff, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sh8000, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sd5184, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sd5185, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, -16'sd5184, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, -16'sd5185, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sd585, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sd586, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, -16'sd586, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, -16'sd587, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sd0, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_REQUEST, 16'sd0, 7'd0, 7'd127, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_REQUEST, 16'sd0, 7'd127, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_REPLY, 16'sd0, 7'd0, 7'd0, 8'h00, 8'h80,
                                        reply_check_byte(8'h00, 8'h80)));
        pending_cmds.push_back(make_cmd(ACT_REPLY, 16'sd0, 7'd0, 7'd0, 8'hff, 8'h7f,
                                        reply_check_byte(8'hff, 8'h7f)));
        pending_cmds.push_back(make_cmd(ACT_REPLY, 16'sd0, 7'd0, 7'd0, 8'hff, 8'hff,
                                        reply_check_byte(8'hff, 8'hff)));
        pending_cmds.push_back(make_cmd(ACT_REPLY, 16'sd0, 7'd0, 7'd0, 8'h34, 8'h12,
                                        reply_check_byte(8'h34, 8'h12) ^ 8'h01));
        pending_cmds.push_back(make_cmd(ACT_REPLY, 16'sd0, 7'd0, 7'd0, 8'h00, 8'h00, 8'hff));
        wait_drained();

        // zero limit, inverted drive, degenerate polynomial
        load_regs(7'd127, 15'd0, 1'b1, 8'd0);
        pending_cmds.push_back(make_cmd(ACT_LINEAR, 16'sh8000, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        pending_cmds.push_back(make_cmd(ACT_CHAR, 16'sh7fff, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0));
        run_random(ITEMS_PER_PHASE, PCT_HEAVY, 0);

        load_regs(7'd0, 15'd32767, 1'b0, 8'd255);
        run_random(ITEMS_PER_PHASE, 0, PCT_HEAVY);

        load_regs(7'($urandom), 15'($urandom), 1'($urandom), 8'd145);
        run_random(ITEMS_PER_PHASE, PCT_LIGHT, PCT_LIGHT);

        load_regs(7'($urandom), 15'($urandom), 1'b1, 8'($urandom));
        run_random(ITEMS_PER_PHASE, 0, 0);

        load_regs(7'($urandom), 15'd32767, 1'b0, 8'h89);
        run_random(ITEMS_PER_PHASE, PCT_LIGHT, PCT_LIGHT);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== motor_command_framer_crc7_top.f =====
+incdir+hdl
hdl/mcf_pkg.sv
hdl/mcf_ifs.sv
hdl/mcf_front.sv
hdl/mcf_queue.sv
hdl/mcf_back.sv
hdl/motor_command_framer_crc7_top.sv
hdl/mcf_sva.sv
tb/tb_motor_command_framer_crc7_top.sv
